// ===== sv/line_pixel_stepper_top_macros.svh =====
`ifndef LINE_PIXEL_STEPPER_TOP_MACROS_SVH
`define LINE_PIXEL_STEPPER_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define LPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define LPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

  localparam int unsigned WinW    = 13;
  localparam int unsigned PitchW  = 16;
  localparam int unsigned BppW    = 7;
  localparam int unsigned ColorW  = 32;
  localparam int unsigned OffW    = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  localparam logic [WinW-1:0]   WinWReset  = 13'd1920;
  localparam logic [WinW-1:0]   WinHReset  = 13'd1080;
  localparam logic [PitchW-1:0] PitchReset = 16'd7680;
  localparam logic [BppW-1:0]   BppReset   = 7'd32;

  typedef enum logic {
    CMD_BEGIN   = 1'b0,
    CMD_ADVANCE = 1'b1
  } lps_cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIN_W = 2'd0,
    REG_WIN_H = 2'd1,
    REG_PITCH = 2'd2,
    REG_BPP   = 2'd3
  } lps_reg_e;

  typedef struct packed {
    logic [WinW-1:0]   win_w;
    logic [WinW-1:0]   win_h;
    logic [PitchW-1:0] pitch;
    logic [BppW-1:0]   bpp;
  } lps_cfg_t;

endpackage

`default_nettype wire

// ===== sv/lps_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lps_cmd_if #(
  parameter int unsigned CW = 16
);
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic signed [CW-1:0] x_start;
  logic signed [CW-1:0] y_start;
  logic signed [CW-1:0] x_end;
  logic signed [CW-1:0] y_end;
  logic [31:0]          pixel_color;

  modport source (
    output valid, command, x_start, y_start, x_end, y_end, pixel_color,
    input  ready
  );
  modport sink (
    input  valid, command, x_start, y_start, x_end, y_end, pixel_color,
    output ready
  );
endinterface

interface lps_pix_if #(
  parameter int unsigned CW = 16
);
  logic                 valid;
  logic                 ready;
  logic                 valid_res;
  logic signed [CW-1:0] pixel_x;
  logic signed [CW-1:0] pixel_y;
  logic [31:0]          out_color;
  logic                 visible;
  logic [31:0]          byte_offset;
  logic                 last;

  modport source (
    output valid, valid_res, pixel_x, pixel_y, out_color, visible, byte_offset, last,
    input  ready
  );
  modport sink (
    input  valid, valid_res, pixel_x, pixel_y, out_color, visible, byte_offset, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/lps_stepper.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "line_pixel_stepper_top_macros.svh"

module lps_stepper #(
  parameter int unsigned CW = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  lps_cmd_if.sink                             cmd,
  output logic                                pix_valid_o,
  input  wire logic                           pix_ready_i,
  output logic                                pix_res_o,
  output logic signed [CW-1:0]                pix_x_o,
  output logic signed [CW-1:0]                pix_y_o,
  output logic [lps_pkg::ColorW-1:0]          pix_color_o,
  output logic                                pix_last_o
);

  localparam int unsigned DxW  = CW + 1;
  localparam int unsigned NdyW = CW + 2;
  localparam int unsigned ErrW = CW + 3;
  localparam int unsigned E2W  = ErrW + 1;

  logic                        acc;
  logic                        is_begin;

  logic signed [CW-1:0]        x_q, x_d, y_q, y_d, ex_q, ex_d, ey_q, ey_d;
  logic signed [DxW-1:0]       dx_q, dx_d, diff_x;
  logic signed [NdyW-1:0]      ndy_q, ndy_d, diff_y;
  logic                        sx_q, sx_d, sy_q, sy_d;
  logic signed [ErrW-1:0]      err_q, err_d;
  logic [lps_pkg::ColorW-1:0]  color_q, color_d;
  logic                        active_q, active_d;

  logic signed [E2W-1:0]       e2;
  logic                        step_x, step_y;
  logic signed [CW-1:0]        x_nx, y_nx;

  logic                        pix_valid_q, pix_valid_d;
  logic                        pix_res_q, pix_res_d;
  logic signed [CW-1:0]        pix_x_q, pix_x_d, pix_y_q, pix_y_d;
  logic [lps_pkg::ColorW-1:0]  pix_color_q, pix_color_d;
  logic                        pix_last_q, pix_last_d;

  assign cmd.ready = !pix_valid_q || pix_ready_i;
  assign acc       = cmd.valid && cmd.ready;
  assign is_begin  = (lps_pkg::lps_cmd_e'(cmd.command) == lps_pkg::CMD_BEGIN);

  assign diff_x = DxW'(cmd.x_end) - DxW'(cmd.x_start);
  assign diff_y = NdyW'(cmd.y_end) - NdyW'(cmd.y_start);

  assign e2     = $signed({err_q, 1'b0});
  assign step_x = (e2 >= E2W'(ndy_q));
  assign step_y = (e2 <= E2W'(dx_q));
  assign x_nx   = step_x ? (sx_q ? x_q - CW'(1) : x_q + CW'(1)) : x_q;
  assign y_nx   = step_y ? (sy_q ? y_q - CW'(1) : y_q + CW'(1)) : y_q;

  always_comb begin
    x_d         = x_q;
    y_d         = y_q;
    ex_d        = ex_q;
    ey_d        = ey_q;
    dx_d        = dx_q;
    ndy_d       = ndy_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    err_d       = err_q;
    color_d     = color_q;
    active_d    = active_q;
    pix_valid_d = pix_valid_q && !pix_ready_i;
    pix_res_d   = pix_res_q;
    pix_x_d     = pix_x_q;
    pix_y_d     = pix_y_q;
    pix_color_d = pix_color_q;
    pix_last_d  = pix_last_q;
    if (acc) begin
      pix_valid_d = 1'b1;
      priority if (is_begin) begin
        x_d         = cmd.x_start;
        y_d         = cmd.y_start;
        ex_d        = cmd.x_end;
        ey_d        = cmd.y_end;
        dx_d        = (cmd.x_end > cmd.x_start) ? diff_x : -diff_x;
        ndy_d       = (cmd.y_end > cmd.y_start) ? -diff_y : diff_y;
        sx_d        = !(cmd.x_start < cmd.x_end);
        sy_d        = !(cmd.y_start < cmd.y_end);
        err_d       = ErrW'(dx_d) + ErrW'(ndy_d);
        color_d     = cmd.pixel_color;
        pix_res_d   = 1'b1;
        pix_x_d     = cmd.x_start;
        pix_y_d     = cmd.y_start;
        pix_color_d = cmd.pixel_color;
        pix_last_d  = (cmd.x_start == cmd.x_end) && (cmd.y_start == cmd.y_end);
        active_d    = !pix_last_d;
      end else if (!active_q) begin
        pix_res_d   = 1'b0;
        pix_x_d     = '0;
        pix_y_d     = '0;
        pix_color_d = '0;
        pix_last_d  = 1'b0;
      end else begin
        x_d         = x_nx;
        y_d         = y_nx;
        err_d       = err_q + (step_x ? ErrW'(ndy_q) : ErrW'(0))
                            + (step_y ? ErrW'(dx_q) : ErrW'(0));
        pix_res_d   = 1'b1;
        pix_x_d     = x_nx;
        pix_y_d     = y_nx;
        pix_color_d = color_q;
        pix_last_d  = (x_nx == ex_q) && (y_nx == ey_q);
        active_d    = !pix_last_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q         <= '0;
      y_q         <= '0;
      ex_q        <= '0;
      ey_q        <= '0;
      dx_q        <= '0;
      ndy_q       <= '0;
      sx_q        <= 1'b0;
      sy_q        <= 1'b0;
      err_q       <= '0;
      color_q     <= '0;
      active_q    <= 1'b0;
      pix_valid_q <= 1'b0;
    end else begin
      x_q         <= x_d;
      y_q         <= y_d;
      ex_q        <= ex_d;
      ey_q        <= ey_d;
      dx_q        <= dx_d;
      ndy_q       <= ndy_d;
      sx_q        <= sx_d;
      sy_q        <= sy_d;
      err_q       <= err_d;
      color_q     <= color_d;
      active_q    <= active_d;
      pix_valid_q <= pix_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_res_q   <= pix_res_d;
    pix_x_q     <= pix_x_d;
    pix_y_q     <= pix_y_d;
    pix_color_q <= pix_color_d;
    pix_last_q  <= pix_last_d;
  end

  assign pix_valid_o = pix_valid_q;
  assign pix_res_o   = pix_res_q;
  assign pix_x_o     = pix_x_q;
  assign pix_y_o     = pix_y_q;
  assign pix_color_o = pix_color_q;
  assign pix_last_o  = pix_last_q;

  `LPS_ASSERT_NXT(a_idle_advance, acc && !is_begin && !active_q, !active_q && !pix_res_q, "advance without a line changed state or produced a pixel")
  `LPS_ASSERT_NXT(a_begin_active, acc && is_begin, pix_res_q && (pix_last_q == !active_q), "line activity after begin disagrees with the last flag")

endmodule

`default_nettype wire

// ===== sv/lps_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "line_pixel_stepper_top_macros.svh"

module lps_emit #(
  parameter int unsigned CW = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire lps_pkg::lps_cfg_t              cfg_i,
  input  wire logic                           pix_valid_i,
  output logic                                pix_ready_o,
  input  wire logic                           pix_res_i,
  input  wire logic signed [CW-1:0]           pix_x_i,
  input  wire logic signed [CW-1:0]           pix_y_i,
  input  wire logic [lps_pkg::ColorW-1:0]     pix_color_i,
  input  wire logic                           pix_last_i,
  lps_pix_if.source                           pix
);

  localparam int unsigned CmpW = (CW > lps_pkg::WinW) ? CW : lps_pkg::WinW;
  localparam int unsigned PyW  = lps_pkg::WinW + lps_pkg::PitchW;
  localparam int unsigned PxW  = lps_pkg::WinW + lps_pkg::BppW - 3;

  logic                              take;
  logic                              vis;
  logic [lps_pkg::WinW-1:0]          xs, ys;
  logic [lps_pkg::BppW-4:0]          bytes_pp;
  logic [PyW-1:0]                    prod_y;
  logic [PxW-1:0]                    prod_x;
  logic [lps_pkg::OffW-1:0]          off;

  logic                              res_valid_q;
  logic                              res_res_q, res_vis_q, res_last_q;
  logic signed [CW-1:0]              res_x_q, res_y_q;
  logic [lps_pkg::ColorW-1:0]        res_color_q;
  logic [lps_pkg::OffW-1:0]          res_off_q;

  assign pix_ready_o = !res_valid_q || pix.ready;
  assign take        = pix_valid_i && pix_ready_o;

  assign vis = pix_res_i && !pix_x_i[CW-1] && !pix_y_i[CW-1]
               && (CmpW'($unsigned(pix_x_i)) < CmpW'(cfg_i.win_w))
               && (CmpW'($unsigned(pix_y_i)) < CmpW'(cfg_i.win_h));

  assign xs       = lps_pkg::WinW'($unsigned(pix_x_i));
  assign ys       = lps_pkg::WinW'($unsigned(pix_y_i));
  assign bytes_pp = cfg_i.bpp[lps_pkg::BppW-1:3];
  assign prod_y   = PyW'(ys) * PyW'(cfg_i.pitch);
  assign prod_x   = PxW'(xs) * PxW'(bytes_pp);
  assign off      = lps_pkg::OffW'(prod_y) + lps_pkg::OffW'(prod_x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (pix_ready_o) begin
      res_valid_q <= pix_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_res_q   <= pix_res_i;
      res_x_q     <= pix_x_i;
      res_y_q     <= pix_y_i;
      res_color_q <= pix_color_i;
      res_last_q  <= pix_last_i;
      res_vis_q   <= vis;
      res_off_q   <= vis ? off : '0;
    end
  end

  assign pix.valid       = res_valid_q;
  assign pix.valid_res   = res_res_q;
  assign pix.pixel_x     = res_x_q;
  assign pix.pixel_y     = res_y_q;
  assign pix.out_color   = res_color_q;
  assign pix.visible     = res_vis_q;
  assign pix.byte_offset = res_off_q;
  assign pix.last        = res_last_q;

  `LPS_ASSERT_IMP(a_hidden_offset, res_valid_q && !res_vis_q, res_off_q == '0, "hidden pixel carries a nonzero byte offset")
  `LPS_ASSERT_IMP(a_empty_result, res_valid_q && !res_res_q, !res_vis_q && !res_last_q && res_x_q == '0 && res_y_q == '0 && res_color_q == '0, "empty result carries pixel data")

endmodule

`default_nettype wire

// ===== sv/line_pixel_stepper_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Line pixel stepper: draws one pixel of a line for every word on the command channel.
// A begin word (command 0) loads both end points and the color and returns the start
// pixel; each advance word (command 1) moves one step along the line and returns the
// next pixel. An advance word with no line in progress returns a word with valid_res 0.
// Each result word carries the pixel position, color, a visible flag against the
// programmed window, the framebuffer byte offset and a last flag at the end point.
// Words pass the step and then the result register. One word is accepted per cycle
// unless the output stalls; the step logic and the offset multipliers each sit in
// their own stage. When the receiver stalls the result register holds, the step stage
// fills, and then cmd_i.ready drops until the receiver takes a word; nothing is lost
// or repeated. Reset clears the line state and loads the window, pitch and pixel size
// registers with 1920, 1080, 7680 and 32. Registers are written through cfg_we_i,
// cfg_idx_i, cfg_data_i only while no word is in flight, which the user must ensure.

module line_pixel_stepper_top #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lps_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [lps_pkg::CfgW-1:0]        cfg_data_i,
  lps_cmd_if.sink                              cmd_i,
  lps_pix_if.source                            pix_o
);

  lps_pkg::lps_cfg_t              cfg_q;
  logic                           pix_valid, pix_ready, pix_res, pix_last;
  logic signed [COORD_BITS-1:0]   pix_x, pix_y;
  logic [lps_pkg::ColorW-1:0]     pix_color;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.win_w <= lps_pkg::WinWReset;
      cfg_q.win_h <= lps_pkg::WinHReset;
      cfg_q.pitch <= lps_pkg::PitchReset;
      cfg_q.bpp   <= lps_pkg::BppReset;
    end else if (cfg_we_i) begin
      unique case (lps_pkg::lps_reg_e'(cfg_idx_i))
        lps_pkg::REG_WIN_W: cfg_q.win_w <= cfg_data_i[lps_pkg::WinW-1:0];
        lps_pkg::REG_WIN_H: cfg_q.win_h <= cfg_data_i[lps_pkg::WinW-1:0];
        lps_pkg::REG_PITCH: cfg_q.pitch <= cfg_data_i[lps_pkg::PitchW-1:0];
        lps_pkg::REG_BPP:   cfg_q.bpp   <= cfg_data_i[lps_pkg::BppW-1:0];
        default:            cfg_q       <= cfg_q;
      endcase
    end
  end

  lps_stepper #(
    .CW (COORD_BITS)
  ) u_stepper (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd         (cmd_i),
    .pix_valid_o (pix_valid),
    .pix_ready_i (pix_ready),
    .pix_res_o   (pix_res),
    .pix_x_o     (pix_x),
    .pix_y_o     (pix_y),
    .pix_color_o (pix_color),
    .pix_last_o  (pix_last)
  );

  lps_emit #(
    .CW (COORD_BITS)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pix_valid_i (pix_valid),
    .pix_ready_o (pix_ready),
    .pix_res_i   (pix_res),
    .pix_x_i     (pix_x),
    .pix_y_i     (pix_y),
    .pix_color_i (pix_color),
    .pix_last_i  (pix_last),
    .pix         (pix_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/line_pixel_stepper_checker.sv =====
`timescale 1ns / 1ps

module line_pixel_stepper_checker #(
  parameter int unsigned CW = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lps_pkg::CfgW-1:0]     cfg_data_i,
  lps_cmd_if                           cmd_mon,
  lps_pix_if                           pix_mon,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  import lps_pkg::*;

  typedef struct packed {
    logic                 valid_res;
    logic signed [CW-1:0] pixel_x;
    logic signed [CW-1:0] pixel_y;
    logic [ColorW-1:0]    out_color;
    logic                 visible;
    logic [OffW-1:0]      byte_offset;
    logic                 last;
  } pixel_word_t;

  logic [WinW-1:0]      win_w;
  logic [WinW-1:0]      win_h;
  logic [PitchW-1:0]    pitch;
  logic [BppW-1:0]      bpp;

  logic signed [CW-1:0] cur_x;
  logic signed [CW-1:0] cur_y;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;
  logic [CW:0]          delta_x;
  logic signed [CW+1:0] neg_delta_y;
  logic                 x_neg;
  logic                 y_neg;
  logic signed [CW+2:0] err;
  logic [ColorW-1:0]    line_color;
  logic                 drawing;

  pixel_word_t          expected_pixels[$];
  int unsigned          pixel_errors;

  // Advances the line walker by one command word and returns the pixel it produces.
  function automatic pixel_word_t step_line(lps_cmd_e cmd, logic signed [CW-1:0] xs,
                                            logic signed [CW-1:0] ys, logic signed [CW-1:0] xe,
                                            logic signed [CW-1:0] ye, logic [ColorW-1:0] c);
    pixel_word_t w;
    int          x0;
    int          y0;
    int          x1;
    int          y1;
    int          e2;
    w = '0;
    if (cmd == CMD_BEGIN) begin
      x0 = int'(xs);
      y0 = int'(ys);
      x1 = int'(xe);
      y1 = int'(ye);
      cur_x = xs;
      cur_y = ys;
      end_x = xe;
      end_y = ye;
      delta_x = (CW+1)'(x1 > x0 ? x1 - x0 : x0 - x1);
      neg_delta_y = (CW+2)'(y1 > y0 ? y0 - y1 : y1 - y0);
      x_neg = !(x0 < x1);
      y_neg = !(y0 < y1);
      err = (CW+3)'(int'(delta_x) + int'(neg_delta_y));
      line_color = c;
      drawing = 1'b1;
    end else if (!drawing) begin
      return w;
    end else begin
      e2 = 2 * int'(err);
      if (e2 >= int'(neg_delta_y)) begin
        err = (CW+3)'(int'(err) + int'(neg_delta_y));
        cur_x = CW'(int'(cur_x) + (x_neg ? -1 : 1));
      end
      if (e2 <= int'(delta_x)) begin
        err = (CW+3)'(int'(err) + int'(delta_x));
        cur_y = CW'(int'(cur_y) + (y_neg ? -1 : 1));
      end
    end
    w.valid_res = 1'b1;
    w.pixel_x = cur_x;
    w.pixel_y = cur_y;
    w.out_color = line_color;
    w.visible = cur_x >= 0 && cur_y >= 0 && int'(cur_x) < int'(win_w) &&
                int'(cur_y) < int'(win_h);
    if (w.visible) begin
      w.byte_offset = OffW'(longint'(cur_y) * longint'(pitch) +
                            longint'(cur_x) * (longint'(bpp) / 8));
    end
    w.last = cur_x == end_x && cur_y == end_y;
    if (w.last) begin
      drawing = 1'b0;
    end
    return w;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      pixel_errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_word_t want;
    if (!rst_ni) begin
      win_w = WinWReset;
      win_h = WinHReset;
      pitch = PitchReset;
      bpp = BppReset;
      cur_x = '0;
      cur_y = '0;
      end_x = '0;
      end_y = '0;
      delta_x = '0;
      neg_delta_y = '0;
      x_neg = 1'b0;
      y_neg = 1'b0;
      err = '0;
      line_color = '0;
      drawing = 1'b0;
      expected_pixels.delete();
      pixel_errors = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (lps_reg_e'(cfg_idx_i))
          REG_WIN_W: win_w = cfg_data_i[WinW-1:0];
          REG_WIN_H: win_h = cfg_data_i[WinW-1:0];
          REG_PITCH: pitch = cfg_data_i[PitchW-1:0];
          REG_BPP:   bpp = cfg_data_i[BppW-1:0];
        endcase
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        expected_pixels.push_back(step_line(lps_cmd_e'(cmd_mon.command), cmd_mon.x_start,
                                            cmd_mon.y_start, cmd_mon.x_end, cmd_mon.y_end,
                                            cmd_mon.pixel_color));
      end
      if (pix_mon.valid && pix_mon.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel word received with no word outstanding");
          pixel_errors++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("valid_res", 32'(want.valid_res), 32'(pix_mon.valid_res));
          check_field("pixel_x", 32'(want.pixel_x), 32'(pix_mon.pixel_x));
          check_field("pixel_y", 32'(want.pixel_y), 32'(pix_mon.pixel_y));
          check_field("out_color", want.out_color, pix_mon.out_color);
          check_field("visible", 32'(want.visible), 32'(pix_mon.visible));
          check_field("byte_offset", want.byte_offset, pix_mon.byte_offset);
          check_field("last", 32'(want.last), 32'(pix_mon.last));
        end
      end
      fail_count_o <= pixel_errors;
      pending_o <= expected_pixels.size();
    end
  end

endmodule

// ===== tb/sv/line_pixel_stepper_top_test.sv =====
`timescale 1ns / 1ps

module line_pixel_stepper_top_test;
  import lps_pkg::*;

  localparam int unsigned CW = 16;
  localparam int PhaseWords = 190;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgW-1:0]     cfg_data;
  int unsigned         mismatches;
  int unsigned         pending;
  int                  sent_count;
  int                  win_w_now;
  int                  win_h_now;

  lps_cmd_if #(.CW(CW)) cmd_bus ();
  lps_pix_if #(.CW(CW)) pix_bus ();

  line_pixel_stepper_top #(
    .COORD_BITS(CW)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .cmd_i      (cmd_bus),
    .pix_o      (pix_bus)
  );

  line_pixel_stepper_checker #(
    .CW(CW)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .cmd_mon      (cmd_bus),
    .pix_mon      (pix_bus),
    .fail_count_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("[line_pixel_stepper_top] ERROR");
    $finish;
  end

  task automatic send_word(lps_cmd_e cmd, int xs, int ys, int xe, int ye, logic [31:0] c);
    bool_idle: begin
      if (!(sent_count >= 450 && sent_count < 750) && $urandom_range(0, 99) < 7) begin
        cmd_bus.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.command <= cmd;
    cmd_bus.x_start <= CW'(xs);
    cmd_bus.y_start <= CW'(ys);
    cmd_bus.x_end <= CW'(xe);
    cmd_bus.y_end <= CW'(ye);
    cmd_bus.pixel_color <= c;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic advance(int n);
    repeat (n) begin
      send_word(CMD_ADVANCE, int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                $urandom);
    end
  endtask

  task automatic wait_idle();
    cmd_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_regs(int w, int h, int p, int b);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx <= REG_WIN_W;
    cfg_data <= CfgW'(w);
    @(posedge clk_i);
    cfg_idx <= REG_WIN_H;
    cfg_data <= CfgW'(h);
    @(posedge clk_i);
    cfg_idx <= REG_PITCH;
    cfg_data <= CfgW'(p);
    @(posedge clk_i);
    cfg_idx <= REG_BPP;
    cfg_data <= CfgW'(b);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_w_now = w % 8192;
    win_h_now = h % 8192;
  endtask

  // Mostly complete lines walked to their end point, some cut short by the next
  // begin word, some followed by stray advance words.
  task automatic line_burst();
    int r;
    int len;
    int dx;
    int dy;
    int sx;
    int sy;
    int n;
    int m;
    r = $urandom_range(0, 99);
    if (r >= 92) begin
      advance($urandom_range(1, 3));
      return;
    end
    len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 60);
    dx = $urandom_range(0, len);
    dy = $urandom_range(0, len);
    case ($urandom_range(0, 5))
      0: dx = 0;
      1: dy = 0;
      default: begin
        if ($urandom_range(0, 1) == 1) dx = len;
        else dy = len;
      end
    endcase
    if ($urandom_range(0, 1) == 1) dx = -dx;
    if ($urandom_range(0, 1) == 1) dy = -dy;
    if ($urandom_range(0, 1) == 1) begin
      sx = int'($urandom_range(0, win_w_now + 8)) - 4;
      sy = int'($urandom_range(0, win_h_now + 8)) - 4;
    end else begin
      sx = int'($urandom_range(0, 65535)) - 32768;
      sy = int'($urandom_range(0, 65535)) - 32768;
    end
    if (sx + dx > 32767 || sx + dx < -32768) dx = -dx;
    if (sy + dy > 32767 || sy + dy < -32768) dy = -dy;
    send_word(CMD_BEGIN, sx, sy, sx + dx, sy + dy, $urandom);
    n = dx < 0 ? -dx : dx;
    m = dy < 0 ? -dy : dy;
    if (m > n) n = m;
    if (r >= 80) begin
      n = (n == 0) ? 0 : $urandom_range(0, n - 1);
    end else if ($urandom_range(0, 4) == 0) begin
      n = n + $urandom_range(1, 3);
    end
    advance(n);
  endtask

  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 1'b0;
    pix_bus.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold > 0) begin
        pix_bus.ready <= 1'b0;
        hold--;
      end else if (!held && sent_count >= 300) begin
        held = 1'b1;
        hold = 160;
        pix_bus.ready <= 1'b0;
      end else if (sent_count >= 700 && sent_count < 1000) begin
        pix_bus.ready <= 1'b1;
      end else begin
        pix_bus.ready <= ($urandom_range(0, 99) >= 7);
      end
      @(posedge clk_i);
    end
  end

  initial begin
    int k;
    int stop;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx <= REG_WIN_W;
    cfg_data <= '0;
    cmd_bus.valid <= 1'b0;
    cmd_bus.command <= CMD_ADVANCE;
    cmd_bus.x_start <= '0;
    cmd_bus.y_start <= '0;
    cmd_bus.x_end <= '0;
    cmd_bus.y_end <= '0;
    cmd_bus.pixel_color <= '0;
    sent_count = 0;
    win_w_now = WinWReset;
    win_h_now = WinHReset;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    advance(1);
    send_word(CMD_BEGIN, 5, 5, 5, 5, 32'h0000_0000);
    advance(1);
    send_word(CMD_BEGIN, -32768, -32768, -32766, -32767, 32'hFFFF_FFFF);
    advance(2);
    send_word(CMD_BEGIN, 32767, 32767, 32765, 32766, 32'h5A5A_A5A5);
    advance(2);
    send_word(CMD_BEGIN, -32768, 0, 32767, 0, 32'h0F0F_0F0F);
    advance(2);
    send_word(CMD_BEGIN, 0, 0, 2, -5, 32'h1234_5678);
    advance(5);
    send_word(CMD_BEGIN, 1919, 1079, 1921, 1076, 32'h8000_0001);
    advance(3);
    send_word(CMD_BEGIN, 0, -1, 0, 1, 32'h7FFF_FFFE);
    advance(2);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: write_regs(1, 1, 0, 8);
        1: write_regs(4096, 4096, 65535, 64);
        2: write_regs(0, 0, 65535, 127);
        3: write_regs(8191, 8191, $urandom_range(0, 65535), 0);
        4: write_regs($urandom_range(1, 4096), $urandom_range(1, 4096),
                      $urandom_range(0, 65535), $urandom_range(8, 64));
        default: write_regs(640, 480, 2560, 24);
      endcase
      stop = sent_count + PhaseWords;
      while (sent_count < stop) line_burst();
    end

    cmd_bus.valid <= 1'b0;
    k = 0;
    @(posedge clk_i);
    while (pending != 0 && k < 10000) begin
      @(posedge clk_i);
      k++;
    end
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("[line_pixel_stepper_top] OK");
    end else begin
      $display("[line_pixel_stepper_top] ERROR");
    end
    $finish;
  end

endmodule
